// ===== src/kmm_pkg.sv =====
package kmm_pkg;

  localparam int unsigned KeyW         = 32;
  localparam int unsigned DataW        = 32;
  localparam int unsigned TableEntries = 16;

  localparam logic signed [DataW-1:0] StopValue = -1;

  typedef enum logic [2:0] {
    StOpened     = 3'd0,
    StOpenFailed = 3'd1,
    StUpdated    = 3'd2,
    StClosed     = 3'd3,
    StStop       = 3'd4,
    StFull       = 3'd5,
    StStopped    = 3'd6
  } status_e;

  // table -> control
  typedef struct packed {
    logic                    hit;
    logic                    free_avail;
    logic signed [DataW-1:0] hit_min;
    logic signed [DataW-1:0] hit_max;
  } lookup_t;

  // control -> table
  typedef struct packed {
    logic open;
    logic close;
    logic upd_min;
    logic upd_max;
  } cmd_t;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] min;
    logic signed [DataW-1:0] max;
  } result_t;

endpackage

// ===== src/kmm_in_if.sv =====
interface kmm_in_if;
  logic                              valid;
  logic                              ready;
  logic        [kmm_pkg::KeyW-1:0]   client_key;
  logic signed [kmm_pkg::DataW-1:0]  sample_value;
  logic                              reply_path_ok;

  modport source (output valid, client_key, sample_value, reply_path_ok, input ready);
  modport sink   (input valid, client_key, sample_value, reply_path_ok, output ready);
endinterface

// ===== src/kmm_out_if.sv =====
interface kmm_out_if;
  logic                              valid;
  logic                              ready;
  kmm_pkg::status_e                  status;
  logic        [kmm_pkg::KeyW-1:0]   report_key;
  logic signed [kmm_pkg::DataW-1:0]  report_min;
  logic signed [kmm_pkg::DataW-1:0]  report_max;

  modport source (output valid, status, report_key, report_min, report_max, input ready);
  modport sink   (input valid, status, report_key, report_min, report_max, output ready);
endinterface

// ===== src/kmm_table.sv =====
module kmm_table #(
  parameter int unsigned Entries = kmm_pkg::TableEntries
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic        [kmm_pkg::KeyW-1:0]  key_i,
  input  logic signed [kmm_pkg::DataW-1:0] val_i,
  input  kmm_pkg::cmd_t                    cmd_i,
  output kmm_pkg::lookup_t                 lookup_o
);

  logic [Entries-1:0] used_q, used_d;
  logic [kmm_pkg::KeyW-1:0]  key_q [Entries];
  logic [kmm_pkg::DataW-1:0] min_q [Entries];
  logic [kmm_pkg::DataW-1:0] max_q [Entries];

  logic [Entries-1:0]        match;
  logic [Entries-1:0]        free_oh;
  logic [kmm_pkg::DataW-1:0] hit_min, hit_max;

  // keys of used entries are unique, so match is one-hot or empty
  always_comb begin
    hit_min = '0;
    hit_max = '0;
    for (int i = 0; i < Entries; i++) begin
      match[i] = used_q[i] && (key_q[i] == key_i);
      if (match[i]) begin
        hit_min = hit_min | min_q[i];
        hit_max = hit_max | max_q[i];
      end
    end
  end

  // lowest free entry
  assign free_oh = ~used_q & (used_q + Entries'(1));

  assign lookup_o.hit        = |match;
  assign lookup_o.free_avail = |(~used_q);
  assign lookup_o.hit_min    = $signed(hit_min);
  assign lookup_o.hit_max    = $signed(hit_max);

  always_comb begin
    used_d = used_q;
    if (cmd_i.open) begin
      used_d = used_q | free_oh;
    end else if (cmd_i.close) begin
      used_d = used_q & ~match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Entries; i++) begin
      if (cmd_i.open && free_oh[i]) begin
        key_q[i] <= key_i;
        min_q[i] <= val_i;
        max_q[i] <= val_i;
      end else begin
        if (cmd_i.upd_min && match[i]) begin
          min_q[i] <= val_i;
        end
        if (cmd_i.upd_max && match[i]) begin
          max_q[i] <= val_i;
        end
      end
    end
  end

  a_match_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("duplicate key in table");

  a_open_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.open |=> $countones(used_q) == $countones($past(used_q)) + 1)
    else $error("open did not take a slot");

  a_close_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.close |=> $countones(used_q) + 1 == $countones($past(used_q)))
    else $error("close did not free a slot");

endmodule

// ===== src/kmm_ctrl.sv =====
module kmm_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  logic signed [kmm_pkg::DataW-1:0] val_i,
  input  logic                             path_ok_i,
  input  kmm_pkg::lookup_t                 lookup_i,
  output kmm_pkg::cmd_t                    cmd_o,
  output kmm_pkg::result_t                 result_o
);

  logic          halted_q, halted_d;
  logic          lt, gt;
  kmm_pkg::cmd_t cmd;

  assign lt = val_i < $signed(lookup_i.hit_min);
  assign gt = val_i > $signed(lookup_i.hit_max);

  always_comb begin
    cmd             = '0;
    halted_d        = halted_q;
    result_o.status = kmm_pkg::StStopped;
    result_o.min    = '0;
    result_o.max    = '0;
    priority if (halted_q) begin
      result_o.status = kmm_pkg::StStopped;
    end else if (!lookup_i.hit) begin
      priority if (val_i == kmm_pkg::StopValue) begin
        result_o.status = kmm_pkg::StStop;
        halted_d        = fire_i;
      end else if (!path_ok_i) begin
        result_o.status = kmm_pkg::StOpenFailed;
      end else if (!lookup_i.free_avail) begin
        result_o.status = kmm_pkg::StFull;
      end else begin
        result_o.status = kmm_pkg::StOpened;
        result_o.min    = val_i;
        result_o.max    = val_i;
        cmd.open        = 1'b1;
      end
    end else if (val_i < 0) begin
      result_o.status = kmm_pkg::StClosed;
      result_o.min    = lookup_i.hit_min;
      result_o.max    = lookup_i.hit_max;
      cmd.close       = 1'b1;
    end else begin
      result_o.status = kmm_pkg::StUpdated;
      cmd.upd_min     = lt;
      cmd.upd_max     = !lt && gt;
      result_o.min    = lt ? val_i : lookup_i.hit_min;
      result_o.max    = (!lt && gt) ? val_i : lookup_i.hit_max;
    end
  end

  assign cmd_o = fire_i ? cmd : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
    end else begin
      halted_q <= halted_d;
    end
  end

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt released without reset");

  a_no_cmd_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> cmd_o == '0)
    else $error("table command while halted");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.open, cmd_o.close, cmd_o.upd_min, cmd_o.upd_max}))
    else $error("conflicting table commands");

endmodule

// ===== src/keyed_min_max_tracker_core.sv =====
// Keyed min/max tracker. Each message (client key, signed sample, reply-path
// flag) yields exactly one result: opened, open failed, updated, closed with
// the key's min and max, stop, table full, or stopped. A -1 from an unknown
// key halts the block until reset. Sustained rate is one message per cycle
// while the result side keeps up; a result leaves the result register after
// its message passes the input register. The rate comes from the parallel
// key match and update of the TABLE_ENTRIES register table, done between the
// input register and the result register, so each message sees the table as
// left by the one before it; a message passes those two registers. A stalled
// result holds the next message in the input register and then blocks the
// input. Area grows with TABLE_ENTRIES 32-bit key comparators.
module keyed_min_max_tracker_core #(
  parameter int unsigned TABLE_ENTRIES = kmm_pkg::TableEntries
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kmm_in_if.sink    in_i,
  kmm_out_if.source out_o
);

  logic                             in_valid_q, in_valid_d;
  logic        [kmm_pkg::KeyW-1:0]  key_q;
  logic signed [kmm_pkg::DataW-1:0] val_q;
  logic                             path_q;

  logic                             out_valid_q, out_valid_d;
  kmm_pkg::result_t                 res_q;
  logic        [kmm_pkg::KeyW-1:0]  rkey_q;

  logic              in_xfer, fire;
  kmm_pkg::lookup_t  lookup;
  kmm_pkg::cmd_t     cmd;
  kmm_pkg::result_t  result;

  assign fire       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;
  assign in_xfer    = in_i.valid && in_i.ready;

  assign in_valid_d  = in_xfer ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q  <= in_i.client_key;
      val_q  <= in_i.sample_value;
      path_q <= in_i.reply_path_ok;
    end
    if (fire) begin
      res_q  <= result;
      rkey_q <= key_q;
    end
  end

  kmm_table #(
    .Entries (TABLE_ENTRIES)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (key_q),
    .val_i    (val_q),
    .cmd_i    (cmd),
    .lookup_o (lookup)
  );

  kmm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .val_i     (val_q),
    .path_ok_i (path_q),
    .lookup_i  (lookup),
    .cmd_o     (cmd),
    .result_o  (result)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = res_q.status;
  assign out_o.report_key = rkey_q;
  assign out_o.report_min = res_q.min;
  assign out_o.report_max = res_q.max;

endmodule
